// ===== hdl/free_list_index_allocator_defines.svh =====
// assertion macros for the free list index allocator checker
`ifndef FREE_LIST_INDEX_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_INDEX_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fla_pkg.sv =====
// shared constants, types and codes for the free list index allocator
package fla_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int SLOT_SPACE = 1024;
    localparam int CAP_LIMIT  = (POOL_DEPTH < SLOT_SPACE) ? POOL_DEPTH : SLOT_SPACE;

    localparam int INDEX_W = 10;
    localparam int CAP_W   = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W   = $clog2(POOL_DEPTH + 1);
    localparam int FRESH_W = $clog2(CAP_LIMIT + 1);

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RECYCLE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_SPACE   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_STACK_FULL = 2'd2;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_POP_READ,
        OP_POP_OUT,
        OP_FRESH,
        OP_NO_SPACE,
        OP_PUSH,
        OP_STACK_FULL,
        OP_CLEAR,
        OP_NOP
    } op_t;

    typedef struct packed {
        logic stack_empty;
        logic stack_full;
        logic fresh_ok;
    } dp_status_t;

endpackage

// ===== hdl/free_list_index_allocator.sv =====
// top level of the free list index allocator: controller plus datapath
// Hands out slot indices: allocate pops the most recently recycled index from
// a lifo free stack, and when the stack is empty issues the next never-used
// index from a bump counter, reporting out of space once that counter reaches
// the capacity (the capacity register, clipped to the pool depth and to 1024).
// Recycle pushes an index with no checking; a push onto a full stack is
// dropped and reported. Clear empties the stack and zeroes the counter.
// An item is taken when start is high and busy is low. Every item yields
// exactly one result, shown for a single cycle with done high; there is no
// way to hold it off, so the receiver must capture it on that edge.
// Timing: the result appears the cycle after the item is taken, except an
// allocate served from the free stack: its index passes the stack memory's
// registered read port, then the result registers, and busy is high in the
// pop state. Items flow one per cycle while busy is low; a pop holds them off.
// Stack contents are undefined after reset and only entries below the stack
// count are ever read, so there is no clearing pass: items are taken from
// the first cycle after reset. Write capacity only while idle.
module free_list_index_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         capacity_we,
    input  logic [fla_pkg::CAP_W-1:0]    capacity_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [fla_pkg::CMD_W-1:0]    command,
    input  logic [fla_pkg::INDEX_W-1:0]  returned_index,
    output logic                         done,
    output logic [fla_pkg::INDEX_W-1:0]  slot_index,
    output logic [fla_pkg::STAT_W-1:0]   status,
    output logic                         from_free_stack
);

    // operation chosen by the controller for this cycle
    fla_pkg::op_t        op;
    // stack empty / full and fresh index available, back from the datapath
    fla_pkg::dp_status_t dp_status;

    fla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .dp_status (dp_status),
        .op        (op),
        .busy      (busy)
    );

    fla_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .capacity_we     (capacity_we),
        .capacity_wdata  (capacity_wdata),
        .returned_index  (returned_index),
        .op              (op),
        .dp_status       (dp_status),
        .done            (done),
        .slot_index      (slot_index),
        .status          (status),
        .from_free_stack (from_free_stack)
    );

endmodule

// ===== hdl/fla_ctrl.sv =====
// controller: decodes accepted items into datapath operations
module fla_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fla_pkg::CMD_W-1:0]  command,
    input  fla_pkg::dp_status_t        dp_status,
    output fla_pkg::op_t               op,
    output logic                       busy
);

    fla_pkg::state_t state_reg;
    fla_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fla_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = fla_pkg::OP_NONE;
        busy       = 1'b0;
        unique case (state_reg)
            fla_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        fla_pkg::CMD_ALLOCATE:
                        begin
                            if (!dp_status.stack_empty)
                            begin
                                op         = fla_pkg::OP_POP_READ;
                                state_next = fla_pkg::ST_POP;
                            end
                            else if (dp_status.fresh_ok)
                            begin
                                op = fla_pkg::OP_FRESH;
                            end
                            else
                            begin
                                op = fla_pkg::OP_NO_SPACE;
                            end
                        end
                        fla_pkg::CMD_RECYCLE:
                        begin
                            op = dp_status.stack_full ? fla_pkg::OP_STACK_FULL
                                                      : fla_pkg::OP_PUSH;
                        end
                        fla_pkg::CMD_CLEAR:
                        begin
                            op = fla_pkg::OP_CLEAR;
                        end
                        default:
                        begin
                            op = fla_pkg::OP_NOP;
                        end
                    endcase
                end
            end
            fla_pkg::ST_POP:
            begin
                // stack read data is ready now
                busy       = 1'b1;
                op         = fla_pkg::OP_POP_OUT;
                state_next = fla_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/fla_datapath.sv =====
// datapath: capacity register, counters, free stack memory and result registers
module fla_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         capacity_we,
    input  logic [fla_pkg::CAP_W-1:0]    capacity_wdata,
    input  logic [fla_pkg::INDEX_W-1:0]  returned_index,
    input  fla_pkg::op_t                 op,
    output fla_pkg::dp_status_t          dp_status,
    output logic                         done,
    output logic [fla_pkg::INDEX_W-1:0]  slot_index,
    output logic [fla_pkg::STAT_W-1:0]   status,
    output logic                         from_free_stack
);

    logic [fla_pkg::CAP_W-1:0]   capacity_reg;
    logic [fla_pkg::FRESH_W-1:0] fresh_cnt_reg;
    logic [fla_pkg::FRESH_W-1:0] fresh_cnt_next;
    logic [fla_pkg::CNT_W-1:0]   stack_cnt_reg;
    logic [fla_pkg::CNT_W-1:0]   stack_cnt_next;
    logic [fla_pkg::CNT_W-1:0]   stack_dec;
    logic                        done_reg;
    logic [fla_pkg::INDEX_W-1:0] rd_data_reg;
    logic [fla_pkg::INDEX_W-1:0] slot_index_reg;
    logic [fla_pkg::STAT_W-1:0]  status_reg;
    logic                        from_stack_reg;

    logic [fla_pkg::INDEX_W-1:0] stack_mem [fla_pkg::POOL_DEPTH];

    assign stack_dec = stack_cnt_reg - fla_pkg::CNT_W'(1);

    assign dp_status.stack_empty = (stack_cnt_reg == '0);
    assign dp_status.stack_full  = (stack_cnt_reg == fla_pkg::CNT_W'(fla_pkg::POOL_DEPTH));
    assign dp_status.fresh_ok    =
        (fla_pkg::CAP_W'(fresh_cnt_reg) < capacity_reg) &&
        (fresh_cnt_reg < fla_pkg::FRESH_W'(fla_pkg::CAP_LIMIT));

    always_comb
    begin
        fresh_cnt_next = fresh_cnt_reg;
        stack_cnt_next = stack_cnt_reg;
        unique case (op)
            fla_pkg::OP_POP_READ: stack_cnt_next = stack_dec;
            fla_pkg::OP_FRESH:    fresh_cnt_next = fresh_cnt_reg + fla_pkg::FRESH_W'(1);
            fla_pkg::OP_PUSH:     stack_cnt_next = stack_cnt_reg + fla_pkg::CNT_W'(1);
            fla_pkg::OP_CLEAR:
            begin
                fresh_cnt_next = '0;
                stack_cnt_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= fla_pkg::CAP_RESET;
            fresh_cnt_reg <= '0;
            stack_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                capacity_reg <= capacity_wdata;
            end
            fresh_cnt_reg <= fresh_cnt_next;
            stack_cnt_reg <= stack_cnt_next;
            done_reg      <= (op != fla_pkg::OP_NONE) && (op != fla_pkg::OP_POP_READ);
        end
    end

    // free stack: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (op == fla_pkg::OP_PUSH)
        begin
            stack_mem[stack_cnt_reg[fla_pkg::ADDR_W-1:0]] <= returned_index;
        end
        if (op == fla_pkg::OP_POP_READ)
        begin
            rd_data_reg <= stack_mem[stack_dec[fla_pkg::ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            fla_pkg::OP_POP_OUT:
            begin
                slot_index_reg <= rd_data_reg;
                status_reg     <= fla_pkg::STATUS_OK;
                from_stack_reg <= 1'b1;
            end
            fla_pkg::OP_FRESH:
            begin
                slot_index_reg <= fla_pkg::INDEX_W'(fresh_cnt_reg);
                status_reg     <= fla_pkg::STATUS_OK;
                from_stack_reg <= 1'b0;
            end
            fla_pkg::OP_NO_SPACE:
            begin
                slot_index_reg <= '0;
                status_reg     <= fla_pkg::STATUS_NO_SPACE;
                from_stack_reg <= 1'b0;
            end
            fla_pkg::OP_STACK_FULL:
            begin
                slot_index_reg <= '0;
                status_reg     <= fla_pkg::STATUS_STACK_FULL;
                from_stack_reg <= 1'b0;
            end
            default:
            begin
                slot_index_reg <= '0;
                status_reg     <= fla_pkg::STATUS_OK;
                from_stack_reg <= 1'b0;
            end
        endcase
    end

    assign done            = done_reg;
    assign slot_index      = slot_index_reg;
    assign status          = status_reg;
    assign from_free_stack = from_stack_reg;

endmodule

// ===== hdl/fla_checker.sv =====
// port-level checker for the free list index allocator, bound to the top level
`include "free_list_index_allocator_defines.svh"

module fla_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [fla_pkg::CMD_W-1:0]    command,
    input logic                         done,
    input logic [fla_pkg::INDEX_W-1:0]  slot_index,
    input logic [fla_pkg::STAT_W-1:0]   status,
    input logic                         from_free_stack
);

    `FLA_ASSERT_NOW(a_fail_zero, done && status != fla_pkg::STATUS_OK, slot_index == '0 && !from_free_stack, "failed item shows a slot")
    `FLA_ASSERT_NOW(a_stack_ok, done && from_free_stack, status == fla_pkg::STATUS_OK, "popped slot with bad status")
    `FLA_ASSERT_NEXT(a_clear_done, start && !busy && command == fla_pkg::CMD_CLEAR, done && status == fla_pkg::STATUS_OK && slot_index == '0 && !from_free_stack, "clear gave no plain result")
    `FLA_ASSERT_NEXT(a_recycle_done, start && !busy && command == fla_pkg::CMD_RECYCLE, done && !from_free_stack && (status == fla_pkg::STATUS_OK || status == fla_pkg::STATUS_STACK_FULL), "recycle result wrong")

endmodule

bind free_list_index_allocator fla_checker u_fla_checker (.*);
